>>> sv/kisd_pkg.sv
// ============================================================================
// kisd_pkg - shared types and constants of the key sorter
// Store depth, field widths, status codes, sequencer states and the control
// group of the shared compare unit.
// ============================================================================
package kisd_pkg;

    // Store depth; the block works for any depth from 2 to 64.
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PICK,
        S_FETCH,
        S_CMP,
        S_PLACE,
        S_DRAIN,
        S_TAIL
    } t_state;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_cmp_ctrl;

endpackage

>>> sv/kisd_cmp_unit.sv
// ============================================================================
// kisd_cmp_unit - shared key comparator with duplicate tracking
// One magnitude compare used by every insertion step, plus a sticky flag that
// records an equal key at the point where an insertion comes to rest.
// ============================================================================
module kisd_cmp_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [kisd_pkg::KEY_W-1:0] i_a,
    input  logic [kisd_pkg::KEY_W-1:0] i_b,
    input  kisd_pkg::t_cmp_ctrl        i_ctrl,
    output logic                      o_gt,
    output logic                      o_dup
);

    logic r_dup;
    logic n_dup;

    assign o_gt = i_a > i_b;

    always_comb begin
        n_dup = r_dup;
        if (i_ctrl.clear) begin
            n_dup = 1'b0;
        end else if (i_ctrl.sample && (i_a == i_b)) begin
            n_dup = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup <= 1'b0;
        end else begin
            r_dup <= n_dup;
        end
    end

    assign o_dup = r_dup;

endmodule

>>> sv/key_insertion_sorter_dup_check_unit.sv
// ============================================================================
// key_insertion_sorter_dup_check_unit - stable key sorter with duplicate check
// Collects a list of key/tag entries, sorts them by insertion and streams
// them out in ascending key order with a list status on the final result.
// ============================================================================
//
// Usage. An entry beat is taken at a rising edge where start is high and
// busy is low. While a list is being loaded busy stays low, so entries may
// arrive on every cycle. The entry with i_entry_last set closes the list;
// busy then rises while the stored entries are sorted in place and streamed
// out. Each result appears for exactly one cycle with o_strobe high; the
// receiver cannot stall, so results are simply presented and dropped.
//
// Timing. Loading writes each entry into the store. The sort uses one read
// port, one write port and one shared comparator; each insertion passes
// through S_PICK and S_FETCH, then one S_CMP step per element shifted, and
// ends in S_CMP or S_PLACE. The drain then delivers one result per cycle,
// each read registered in the store and then in the output registers. busy
// falls in the cycle that carries the final result.
//
// If more entries arrive than the store holds, the surplus is dropped and
// the closing entry yields a single result with status overflow, in the
// cycle after it is taken, without busy rising. Reset empties the list and
// clears the strobe; the store contents need no reset, since only entries
// written in the current list are ever read.
//
module key_insertion_sorter_dup_check_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kisd_pkg::KEY_W-1:0]    i_entry_key,
    input  logic [kisd_pkg::TAG_W-1:0]    i_entry_tag,
    input  logic                          i_entry_last,
    output logic                          o_strobe,
    output logic [kisd_pkg::KEY_W-1:0]    o_sorted_key,
    output logic [kisd_pkg::TAG_W-1:0]    o_sorted_tag,
    output logic                          o_result_last,
    output logic [kisd_pkg::STATUS_W-1:0] o_list_status
);

    localparam logic [kisd_pkg::CNT_W-1:0] CNT_MAX =
        kisd_pkg::CNT_W'(kisd_pkg::MAX_ENTRIES);
    localparam logic [kisd_pkg::CNT_W-1:0] CNT_ONE = kisd_pkg::CNT_W'(1);
    localparam logic [kisd_pkg::CNT_W-1:0] CNT_TWO = kisd_pkg::CNT_W'(2);

    // Entry store: one write and one registered read per cycle.
    kisd_pkg::t_entry r_mem [kisd_pkg::MAX_ENTRIES];
    kisd_pkg::t_entry r_rd;
    logic                       wr_en;
    logic [kisd_pkg::IDX_W-1:0] wr_addr;
    kisd_pkg::t_entry           wr_data;
    logic [kisd_pkg::IDX_W-1:0] rd_addr;

    // Sequencer state.
    kisd_pkg::t_state           r_state, n_state;
    logic [kisd_pkg::CNT_W-1:0] r_cnt, n_cnt;   // entries held while loading
    logic                       r_ovf, n_ovf;   // an entry was dropped
    logic [kisd_pkg::CNT_W-1:0] r_n, n_n;       // list length for sort/drain
    logic [kisd_pkg::CNT_W-1:0] r_i, n_i;       // element being inserted
    logic [kisd_pkg::CNT_W-1:0] r_p, n_p;       // hole position of insertion
    logic [kisd_pkg::CNT_W-1:0] r_j, n_j;       // drain read index
    kisd_pkg::t_entry           r_k, n_k;       // entry being inserted
    logic                       r_pend, n_pend; // drain read data arrives
    logic                       r_pend_last, n_pend_last;

    // Output registers.
    logic                          r_o_vld, n_o_vld;
    logic [kisd_pkg::KEY_W-1:0]    r_o_key, n_o_key;
    logic [kisd_pkg::TAG_W-1:0]    r_o_tag, n_o_tag;
    logic                          r_o_last, n_o_last;
    logic [kisd_pkg::STATUS_W-1:0] r_o_status, n_o_status;

    // Shared comparator.
    kisd_pkg::t_cmp_ctrl cmp_ctrl;
    logic                cmp_gt;
    logic                cmp_dup;

    logic accept;

    assign accept = start && !busy;
    assign busy   = (r_state != kisd_pkg::S_LOAD);

    kisd_cmp_unit u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (r_rd.key),
        .i_b     (r_k.key),
        .i_ctrl  (cmp_ctrl),
        .o_gt    (cmp_gt),
        .o_dup   (cmp_dup)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_i         = r_i;
        n_p         = r_p;
        n_j         = r_j;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;

        wr_en   = 1'b0;
        wr_addr = r_p[kisd_pkg::IDX_W-1:0];
        wr_data = r_k;
        rd_addr = r_i[kisd_pkg::IDX_W-1:0];

        cmp_ctrl.clear  = 1'b0;
        cmp_ctrl.sample = 1'b0;

        // A drain read issued last cycle is now in r_rd: move it out.
        n_o_vld    = r_pend;
        n_o_key    = r_rd.key;
        n_o_tag    = r_rd.tag;
        n_o_last   = r_pend_last;
        n_o_status = (r_pend_last && cmp_dup) ? kisd_pkg::ST_DUP : kisd_pkg::ST_OK;

        unique case (r_state)
            kisd_pkg::S_LOAD: begin
                if (accept) begin
                    if (r_cnt < CNT_MAX) begin
                        wr_en        = 1'b1;
                        wr_addr      = r_cnt[kisd_pkg::IDX_W-1:0];
                        wr_data.key  = i_entry_key;
                        wr_data.tag  = i_entry_tag;
                        n_cnt        = r_cnt + CNT_ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_entry_last) begin
                        n_cnt          = '0;
                        n_ovf          = 1'b0;
                        cmp_ctrl.clear = 1'b1;
                        if (r_ovf || (r_cnt == CNT_MAX)) begin
                            n_o_vld    = 1'b1;
                            n_o_key    = '0;
                            n_o_tag    = '0;
                            n_o_last   = 1'b1;
                            n_o_status = kisd_pkg::ST_OVF;
                        end else begin
                            n_n = r_cnt + CNT_ONE;
                            n_j = '0;
                            n_i = CNT_ONE;
                            // A single entry is already in order.
                            n_state = (r_cnt == '0) ? kisd_pkg::S_DRAIN
                                                    : kisd_pkg::S_PICK;
                        end
                    end
                end
            end

            kisd_pkg::S_PICK: begin
                rd_addr = r_i[kisd_pkg::IDX_W-1:0];
                n_state = kisd_pkg::S_FETCH;
            end

            kisd_pkg::S_FETCH: begin
                n_k     = r_rd;
                n_p     = r_i;
                rd_addr = kisd_pkg::IDX_W'(r_i - CNT_ONE);
                n_state = kisd_pkg::S_CMP;
            end

            kisd_pkg::S_CMP: begin
                // r_rd holds the entry just left of the hole.
                wr_en = 1'b1;
                if (cmp_gt) begin
                    wr_data = r_rd;
                    n_p     = r_p - CNT_ONE;
                    rd_addr = kisd_pkg::IDX_W'(r_p - CNT_TWO);
                    if (r_p == CNT_ONE) begin
                        n_state = kisd_pkg::S_PLACE;
                    end
                end else begin
                    wr_data         = r_k;
                    cmp_ctrl.sample = 1'b1;
                    if ((r_i + CNT_ONE) == r_n) begin
                        n_state = kisd_pkg::S_DRAIN;
                    end else begin
                        n_i     = r_i + CNT_ONE;
                        n_state = kisd_pkg::S_PICK;
                    end
                end
            end

            kisd_pkg::S_PLACE: begin
                wr_en   = 1'b1;
                wr_data = r_k;
                if ((r_i + CNT_ONE) == r_n) begin
                    n_state = kisd_pkg::S_DRAIN;
                end else begin
                    n_i     = r_i + CNT_ONE;
                    n_state = kisd_pkg::S_PICK;
                end
            end

            kisd_pkg::S_DRAIN: begin
                rd_addr     = r_j[kisd_pkg::IDX_W-1:0];
                n_pend      = 1'b1;
                n_pend_last = ((r_j + CNT_ONE) == r_n);
                if ((r_j + CNT_ONE) == r_n) begin
                    n_state = kisd_pkg::S_TAIL;
                end else begin
                    n_j = r_j + CNT_ONE;
                end
            end

            kisd_pkg::S_TAIL: begin
                // The final read is being registered out on this edge.
                n_state = kisd_pkg::S_LOAD;
            end

            default: begin
                n_state = kisd_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kisd_pkg::S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_o_vld     <= n_o_vld;
        end
    end

    // Working registers of the sort and the output payload carry no reset.
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_i        <= n_i;
        r_p        <= n_p;
        r_j        <= n_j;
        r_k        <= n_k;
        r_o_key    <= n_o_key;
        r_o_tag    <= n_o_tag;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
    end

    assign o_strobe      = r_o_vld;
    assign o_sorted_key  = r_o_key;
    assign o_sorted_tag  = r_o_tag;
    assign o_result_last = r_o_last;
    assign o_list_status = r_o_status;

    // The hole is never at the left end while a neighbour is compared.
    a_cmp_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kisd_pkg::S_CMP) |-> (r_p != '0))
        else $error("insertion compare with hole at position zero");

    // The load count never passes the store depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_MAX))
        else $error("entry count beyond store depth");

    // Results of one run follow each other on consecutive cycles.
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result_last) |=> o_strobe)
        else $error("gap inside a sorted run");

    // Only the final beat of a run carries a status other than ok.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result_last) |-> (o_list_status == kisd_pkg::ST_OK))
        else $error("status on a result that is not the final one");

    // A result beat is never produced in the compare or place steps of the sort.
    a_no_strobe_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kisd_pkg::S_CMP || r_state == kisd_pkg::S_PLACE) |-> !o_strobe)
        else $error("result strobe during sorting");

endmodule
